// ----- rtl/core/mexp_pkg.sv -----
// Shared constants for the modular exponentiation core.
package mexp_pkg;

    localparam int EXP_BITS = 63;                    // exponent bits that take part
    localparam int MOD_W    = 31;
    localparam int BASE_W   = 32;
    localparam int EXP_W    = 63;
    localparam int CNT_W    = $clog2(EXP_BITS + 1);
    localparam int STEP_W   = $clog2(BASE_W);

    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

endpackage

// ----- rtl/core/mexp_in_if.sv -----
// Input channel: base and exponent with valid/ready.
interface mexp_in_if import mexp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

// ----- rtl/core/mexp_out_if.sv -----
// Output channel: power with valid/ready.
interface mexp_out_if import mexp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

// ----- rtl/core/modular_exponentiation_core.sv -----
// Modular exponentiation core: base^exponent mod modulus by square-and-multiply.
//
// Usage: an item (base, exponent) transfers on i_in when valid and ready are
// both high; the result transfers on o_out the same way. The modulus is
// written through i_cfg_we/i_cfg_data while the core is idle.
// One item is worked at a time: i_in.ready is high only when the sequencer
// is idle. A single bit-serial modular multiplier (one multiplier bit and two
// conditional subtractions per cycle) does all the work: the base is first
// reduced (S_REDUCE), then every exponent bit costs a squaring (S_SQR), a
// multiply (S_MUL) when the bit is set, and a bookkeeping step (S_NEXT).
// A zero exponent or zero modulus skips the multiplier and goes straight
// to the DONE state.
// The result sits in an output register, so the next item may transfer
// while it waits; a finished item holds in the DONE state until the output
// register is free. Reset (synchronous, active low) drops any work and any
// pending result and restores the modulus to 1000000007.
module modular_exponentiation_core import mexp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [MOD_W-1:0] i_cfg_data,
    mexp_in_if.sink          i_in,
    mexp_out_if.source       o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQR,
        S_MUL,
        S_NEXT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [MOD_W-1:0]    r_mod;
    logic [EXP_BITS-1:0] r_exp;
    logic [CNT_W-1:0]    r_bit_cnt;
    logic [MOD_W-1:0]    r_b;
    logic [MOD_W-1:0]    r_acc;
    logic [MOD_W-1:0]    r_r;
    logic [MOD_W-1:0]    r_mcand;
    logic [BASE_W-1:0]   r_mplier;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_valid;
    logic [MOD_W-1:0]    r_power;

    logic [EXP_BITS-1:0] in_exp;
    logic                in_xfer;
    logic                out_xfer;
    logic [MOD_W:0]      t1;
    logic [MOD_W:0]      t1r;
    logic [MOD_W:0]      t2;
    logic [MOD_W:0]      t2r;
    logic [MOD_W-1:0]    step_res;

    assign in_exp   = i_in.exponent[EXP_BITS-1:0];
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_out_valid && o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.power = r_power;

    // One step of the interleaved multiplier: r = 2r + bit*mcand, kept below m.
    always_comb begin
        t1       = {r_r, 1'b0};
        t1r      = (t1 >= {1'b0, r_mod}) ? (t1 - {1'b0, r_mod}) : t1;
        t2       = {1'b0, t1r[MOD_W-1:0]}
                   + (r_mplier[BASE_W-1] ? {1'b0, r_mcand} : '0);
        t2r      = (t2 >= {1'b0, r_mod}) ? (t2 - {1'b0, r_mod}) : t2;
        step_res = t2r[MOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= MOD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mod <= i_cfg_data;
            end
            // the DONE state reloads the output register itself
            if (out_xfer && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_exp <= in_exp;
                        if (in_exp == '0) begin
                            r_acc   <= MOD_W'(1);
                            r_state <= S_DONE;
                        end else if (r_mod == '0) begin
                            r_acc   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            // base mod m as 1 * base, scanning all base bits
                            r_r      <= '0;
                            r_mcand  <= MOD_W'(1);
                            r_mplier <= i_in.base;
                            r_step   <= STEP_W'(BASE_W - 1);
                            r_state  <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE, S_SQR, S_MUL: begin
                    if (r_step == '0) begin
                        r_r      <= '0;
                        r_step   <= STEP_W'(MOD_W - 1);
                        if (r_state == S_REDUCE) begin
                            r_b       <= step_res;
                            r_bit_cnt <= CNT_W'(EXP_BITS);
                            r_acc     <= (r_mod == MOD_W'(1)) ? '0 : MOD_W'(1);
                            r_mcand   <= (r_mod == MOD_W'(1)) ? '0 : MOD_W'(1);
                            r_mplier  <= (r_mod == MOD_W'(1)) ? '0
                                         : {MOD_W'(1), {(BASE_W - MOD_W){1'b0}}};
                            r_state   <= S_SQR;
                        end else if (r_state == S_SQR && r_exp[EXP_BITS-1]) begin
                            r_acc    <= step_res;
                            r_mcand  <= r_b;
                            r_mplier <= {step_res, {(BASE_W - MOD_W){1'b0}}};
                            r_state  <= S_MUL;
                        end else begin
                            r_acc   <= step_res;
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_r      <= step_res;
                        r_mplier <= {r_mplier[BASE_W-2:0], 1'b0};
                        r_step   <= r_step - 1'b1;
                    end
                end
                S_NEXT: begin
                    r_exp     <= r_exp << 1;
                    r_bit_cnt <= r_bit_cnt - 1'b1;
                    if (r_bit_cnt == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_mcand  <= r_acc;
                        r_mplier <= {r_acc, {(BASE_W - MOD_W){1'b0}}};
                        r_state  <= S_SQR;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_power     <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_zero_exp_gives_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && in_exp == '0) |=> (r_state == S_DONE && r_acc == MOD_W'(1)))
        else $error("zero exponent did not yield one");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("output valid rose outside the DONE state");

    a_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQR || r_state == S_MUL || r_state == S_NEXT) |-> r_bit_cnt != '0)
        else $error("exponent bit counter ran out while working");

endmodule

// ----- test/modular_exponentiation_core_tb.sv -----
// Self-checking testbench for the modular exponentiation core.
module modular_exponentiation_core_tb import mexp_pkg::*; ();

    localparam int     PERIOD        = 12;
    localparam longint LIMIT_TIME    = 64'd30_000_000;
    localparam int     RANDOM_PHASES = 5;
    localparam int     PHASE_ITEMS   = 16;
    localparam int     MAX_REPORTS   = 10;

    localparam logic [BASE_W-1:0] BASE_ALL = '1;
    localparam logic [EXP_W-1:0]  EXP_ALL  = '1;
    localparam logic [MOD_W-1:0]  MOD_MAX  = '1;

    typedef struct packed {
        logic              load;       // write the modulus before this item
        logic [MOD_W-1:0]  modulus;
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        logic              known;      // power below is typed in
        logic [MOD_W-1:0]  power;
    } t_vector;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             cfg_we   = 1'b0;
    logic [MOD_W-1:0] cfg_data = '0;

    mexp_in_if  feed_ch ();
    mexp_out_if result_ch ();

    modular_exponentiation_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (feed_ch),
        .o_out      (result_ch)
    );

    logic [MOD_W-1:0] modulus_shadow = MOD_RESET;
    logic [MOD_W-1:0] pending_powers [$];
    logic [MOD_W-1:0] due_power;
    int               mismatches = 0;
    int               burst_left = 0;

    t_vector directed_vec [23] = '{
        '{1'b0, MOD_RESET, 32'd0,          63'd0,      1'b1, 31'd1},
        '{1'b0, MOD_RESET, BASE_ALL,       63'd0,      1'b1, 31'd1},
        '{1'b0, MOD_RESET, 32'd0,          63'd1,      1'b1, 31'd0},
        '{1'b0, MOD_RESET, 32'd1,          EXP_ALL,    1'b1, 31'd1},
        '{1'b0, MOD_RESET, 32'd2,          63'd10,     1'b1, 31'd1024},
        '{1'b0, MOD_RESET, BASE_ALL,       EXP_ALL,    1'b0, 31'd0},
        '{1'b0, MOD_RESET, 32'd1000000007, 63'd5,      1'b1, 31'd0},
        '{1'b0, MOD_RESET, 32'd1000000006, 63'd2,      1'b1, 31'd1},
        '{1'b0, MOD_RESET, 32'd1000000006, 63'd3,      1'b1, 31'd1000000006},
        '{1'b0, MOD_RESET, 32'd123456789,  63'h5555_5555_5555_5555, 1'b0, 31'd0},
        // modulus of one
        '{1'b1, 31'd1,     32'd5,          63'd0,      1'b1, 31'd1},
        '{1'b0, 31'd1,     BASE_ALL,       EXP_ALL,    1'b1, 31'd0},
        // modulus of zero: no reduction, zero for any nonzero exponent
        '{1'b1, 31'd0,     32'd7,          63'd0,      1'b1, 31'd1},
        '{1'b0, 31'd0,     32'd7,          63'd1,      1'b1, 31'd0},
        '{1'b0, 31'd0,     BASE_ALL,       EXP_ALL,    1'b1, 31'd0},
        '{1'b1, MOD_MAX,   BASE_ALL,       EXP_ALL,    1'b0, 31'd0},
        '{1'b0, MOD_MAX,   32'd2147483646, 63'd2,      1'b1, 31'd1},
        '{1'b0, MOD_MAX,   32'h8000_0000,  63'd1,      1'b1, 31'd1},
        '{1'b0, MOD_MAX,   32'd3,          63'h4000_0000_0000_0000, 1'b0, 31'd0},
        '{1'b1, 31'd2,     32'd3,          63'd7,      1'b1, 31'd1},
        '{1'b0, 31'd2,     32'd4,          63'd1,      1'b1, 31'd0},
        '{1'b1, 31'd13,    32'd2,          63'd12,     1'b1, 31'd1},
        '{1'b0, 31'd13,    32'hAAAA_AAAA,  63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 31'd0}
    };

    always #(PERIOD / 2) clk = ~clk;

    // Square-and-multiply from the top exponent bit down, reducing every product.
    function automatic logic [MOD_W-1:0] mod_power(input logic [BASE_W-1:0] b,
                                                   input logic [EXP_W-1:0]  e,
                                                   input logic [MOD_W-1:0]  m);
        longint unsigned acc;
        longint unsigned base_red;
        longint unsigned mm;
        if (e == '0) return MOD_W'(1);
        if (m == '0) return '0;
        mm       = 64'(m);
        base_red = 64'(b) % mm;
        acc      = 64'd1 % mm;
        for (int i = EXP_BITS - 1; i >= 0; i--) begin
            acc = (acc * acc) % mm;
            if (e[i]) acc = (acc * base_red) % mm;
        end
        return MOD_W'(acc);
    endfunction

    // Drain every pending power, then write the modulus.
    task automatic write_modulus(input logic [MOD_W-1:0] value);
        feed_ch.valid <= 1'b0;
        while (pending_powers.size() != 0) @(negedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        modulus_shadow = value;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e,
                             input logic known, input logic [MOD_W-1:0] want);
        logic [MOD_W-1:0] predicted;
        if (burst_left == 0) begin
            feed_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 5);
        end
        burst_left--;
        predicted = known ? want : mod_power(b, e, modulus_shadow);
        feed_ch.valid    <= 1'b1;
        feed_ch.base     <= b;
        feed_ch.exponent <= e;
        do @(posedge clk); while (!feed_ch.ready);
        pending_powers = {pending_powers, predicted};
        @(negedge clk);
    endtask

    initial begin
        logic [BASE_W-1:0] b;
        logic [EXP_W-1:0]  e;
        logic [MOD_W-1:0]  m;
        feed_ch.valid    = 1'b0;
        feed_ch.base     = '0;
        feed_ch.exponent = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_vec[i]) begin
            if (directed_vec[i].load) write_modulus(directed_vec[i].modulus);
            send_item(directed_vec[i].base, directed_vec[i].exponent,
                      directed_vec[i].known, directed_vec[i].power);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: m = MOD_RESET;
                1: m = MOD_W'($urandom_range(2, 1000));
                2: m = MOD_W'($urandom) | 31'h4000_0000;
                3: m = MOD_W'($urandom);
                default: begin
                    case ($urandom_range(0, 3))
                        0:       m = '0;
                        1:       m = 31'd1;
                        2:       m = MOD_MAX;
                        default: m = MOD_W'($urandom_range(3, 50));
                    endcase
                end
            endcase
            write_modulus(m);
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(0, 4))
                    0, 1:    b = $urandom;
                    2:       b = $urandom_range(0, 20);
                    3:       b = BASE_W'(m) + $urandom_range(0, 2) - 32'd1;
                    default: b = $urandom_range(0, 1) ? BASE_ALL : 32'h8000_0000;
                endcase
                case ($urandom_range(0, 7))
                    0, 1, 2: e = EXP_W'({$urandom, $urandom});
                    3:       e = EXP_W'($urandom_range(0, 70));
                    4:       e = '0;
                    5:       e = EXP_ALL;
                    6:       e = EXP_W'(1) << $urandom_range(0, EXP_W - 1);
                    default: e = EXP_W'({$urandom, $urandom} >> $urandom_range(1, 62));
                endcase
                send_item(b, e, 1'b0, '0);
            end
        end

        feed_ch.valid <= 1'b0;
        while (pending_powers.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0) begin
            $display("modular_exponentiation_core: match");
        end else begin
            $display("modular_exponentiation_core: mismatch");
        end
        $finish;
    end

    // Receiver: stall on a rotating pattern, refreshed now and then.
    initial begin
        logic [15:0] pattern;
        int          hold;
        result_ch.ready = 1'b0;
        pattern         = '1;
        hold            = 0;
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                hold = $urandom_range(16, 200);
                if ($urandom_range(0, 2) == 0) pattern = '1;
                else pattern = 16'($urandom);
            end
            hold--;
            result_ch.ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_powers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected power transfer: %0d", result_ch.power);
            end else begin
                due_power = pending_powers.pop_front();
                if (result_ch.power !== due_power) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("power: expected %0d, got %0d", due_power, result_ch.power);
                end
            end
        end
    end

    initial begin
        #(LIMIT_TIME);
        $display("modular_exponentiation_core: mismatch");
        $finish;
    end

endmodule
